[src/assert_macros.svh]
// Assertion helpers for the RTL files; bfa_datapath includes them.
// Both macros expect a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside of reset.
`define BFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define BFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[src/bfa_pkg.sv]
package bfa_pkg;

  // Field widths.
  localparam int FRAME_W = 12;
  localparam int COUNT_W = FRAME_W + 1;
  localparam int MODE_W  = 2;

  // Map geometry: the used bits are stored as words of WORD_W bits.
  localparam int MAX_FRAMES = 1 << FRAME_W;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int WORDS      = MAX_FRAMES / WORD_W;
  localparam int ADDR_W     = FRAME_W - BIT_W;
  localparam int BYTES      = WORD_W / 8;
  localparam int BYTE_W     = $clog2(BYTES);

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FRAMES);

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic rd_req;
    logic scan_clr;
    logic scan_rd;
    logic rmw_commit;
    logic scan_commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_more;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

[src/bfa_channels.sv]
// Request channel: one allocator request.
interface bfa_req_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [FRAME_W-1:0] frame;

  modport source (output valid, output mode, output frame, input ready);
  modport sink (input valid, input mode, input frame, output ready);
endinterface

// Response channel: one result per request.
interface bfa_rsp_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_result;
  logic               ok;

  modport source (output valid, output frame_result, output ok, input ready);
  modport sink (input valid, input frame_result, input ok, output ready);
endinterface

// Configuration channel: writes the frame count register.
interface bfa_cfg_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/bfa_ctrl.sv]
module bfa_ctrl import bfa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  logic    req_is_find,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    READ,
    MODIFY,
    SCAN,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands for the datapath.
  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = (state == IDLE);
    case (state)
      IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          if (req_is_find) begin
            cmd.scan_clr = 1'b1;
            state_next   = SCAN;
          end else begin
            state_next = READ;
          end
        end
      end
      READ: begin
        cmd.rd_req = 1'b1;
        state_next = MODIFY;
      end
      MODIFY: begin
        if (status.out_free) begin
          cmd.rmw_commit = 1'b1;
          state_next     = IDLE;
        end
      end
      SCAN: begin
        cmd.scan_rd = status.scan_more;
        if (status.scan_done) begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (status.out_free) begin
          cmd.scan_commit = 1'b1;
          state_next      = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/bfa_datapath.sv]
`include "assert_macros.svh"

module bfa_datapath import bfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [FRAME_W-1:0] in_frame,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FRAME_W-1:0] out_frame,
  output logic               out_ok
);

  // Used-bit map and one valid bit per word; an invalid word reads as all free.
  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  row_valid;

  logic [COUNT_W-1:0] eff_count;
  logic [MODE_W-1:0]  req_mode;
  logic [FRAME_W-1:0] req_frame;

  // Read stage.
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              rd_row_ok;
  logic [ADDR_W-1:0] rd_addr_q;
  logic              rd_tag;

  // Scan counter and per-byte search stage.
  logic [ADDR_W:0]   scan_addr;
  logic              issued_all;
  logic [BYTES-1:0]  byte_free;
  logic [2:0]        byte_low [BYTES];
  logic [BYTES-1:0]  s2_free;
  logic [2:0]        s2_low [BYTES];
  logic [ADDR_W-1:0] s2_addr;
  logic              s2_tag;
  logic [BYTE_W-1:0] sel_byte;
  logic              hit;
  logic [FRAME_W-1:0] hit_frame;

  // Word under test and read-modify-write terms.
  logic [WORD_W-1:0]  cur_word;
  logic [WORD_W-1:0]  range_mask;
  logic [WORD_W-1:0]  free_bits;
  logic [ADDR_W:0]    cnt_hi;
  logic [BIT_W-1:0]   cnt_lo;
  logic [BIT_W-1:0]   frame_bit;
  logic               cur_bit;
  logic               in_range;
  logic               is_alloc;
  logic               is_free;
  logic               rmw_ok;
  logic [WORD_W-1:0]  new_word;
  logic [FRAME_W-1:0] rmw_result;

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode  <= in_mode;
      req_frame <= in_frame;
    end
  end

  // Frame count, saturated to the map size on write.
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_count <= MAX_COUNT;
    end else if (cfg_we) begin
      eff_count <= (cfg_data > MAX_COUNT) ? MAX_COUNT : cfg_data;
    end
  end

  // Read port address: the scan counter or the requested frame's word.
  assign rd_en   = cmd.rd_req || cmd.scan_rd;
  assign rd_addr = cmd.scan_rd ? scan_addr[ADDR_W-1:0] : req_frame[FRAME_W-1:BIT_W];

  // Map memory with registered read data.
  always_ff @(posedge clk) begin
    if (cmd.rmw_commit) begin
      mem[req_frame[FRAME_W-1:BIT_W]] <= new_word;
    end
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_row_ok <= row_valid[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Word valid bits: reset and any frame count write clear the whole map.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      row_valid <= '0;
    end else if (cmd.rmw_commit) begin
      row_valid[req_frame[FRAME_W-1:BIT_W]] <= 1'b1;
    end
  end

  assign cur_word = rd_row_ok ? rd_data : '0;

  // Frames at or beyond the count, and frame zero, count as used for the search.
  assign cnt_hi = eff_count[COUNT_W-1:BIT_W];
  assign cnt_lo = eff_count[BIT_W-1:0];

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      if ({1'b0, rd_addr_q} < cnt_hi) begin
        range_mask[b] = 1'b0;
      end else if ({1'b0, rd_addr_q} == cnt_hi) begin
        range_mask[b] = (BIT_W'(b) >= cnt_lo);
      end else begin
        range_mask[b] = 1'b1;
      end
    end
    if (rd_addr_q == '0) begin
      range_mask[0] = 1'b1;
    end
  end

  assign free_bits = ~(cur_word | range_mask);

  // Per-byte free flag and lowest free bit within each byte.
  always_comb begin
    for (int k = 0; k < BYTES; k++) begin
      byte_free[k] = |free_bits[k*8 +: 8];
      byte_low[k]  = '0;
      for (int j = 7; j >= 0; j--) begin
        if (free_bits[k*8 + j]) begin
          byte_low[k] = 3'(j);
        end
      end
    end
  end

  // Lowest byte with a free frame.
  always_comb begin
    sel_byte = '0;
    for (int k = BYTES - 1; k >= 0; k--) begin
      if (s2_free[k]) begin
        sel_byte = BYTE_W'(k);
      end
    end
  end

  // Search stage payload.
  always_ff @(posedge clk) begin
    s2_free <= byte_free;
    s2_low  <= byte_low;
    s2_addr <= rd_addr_q;
  end

  // Scan counter, pipeline tags and first-hit capture.
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clr) begin
      scan_addr <= '0;
      rd_tag    <= 1'b0;
      s2_tag    <= 1'b0;
      hit       <= 1'b0;
    end else begin
      rd_tag <= cmd.scan_rd;
      s2_tag <= rd_tag;
      if (cmd.scan_rd) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (s2_tag && !hit && (|s2_free)) begin
        hit       <= 1'b1;
        hit_frame <= {s2_addr, sel_byte, s2_low[sel_byte]};
      end
    end
  end

  assign issued_all = (scan_addr == (ADDR_W + 1)'(WORDS));

  // Allocate and free against the word just read.
  assign frame_bit  = req_frame[BIT_W-1:0];
  assign cur_bit    = cur_word[frame_bit];
  assign in_range   = ({1'b0, req_frame} < eff_count);
  assign is_alloc   = (req_mode == MODE_ALLOC);
  assign is_free    = (req_mode == MODE_FREE);
  assign rmw_ok     = in_range && ((is_alloc && !cur_bit) || (is_free && cur_bit));
  assign rmw_result = (is_alloc && rmw_ok) ? req_frame : '0;

  always_comb begin
    new_word = cur_word;
    if (rmw_ok) begin
      new_word[frame_bit] = is_alloc;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rmw_commit || cmd.scan_commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rmw_commit) begin
      out_frame <= rmw_result;
      out_ok    <= rmw_ok;
    end else if (cmd.scan_commit) begin
      out_frame <= hit ? hit_frame : '0;
      out_ok    <= hit;
    end
  end

  assign status.scan_more = !hit && !issued_all;
  assign status.scan_done = hit || (issued_all && !rd_tag && !s2_tag);
  assign status.out_free  = !out_valid || out_ready;

  `BFA_ASSERT_IMP(a_hit_nonzero, hit, hit_frame != '0, "search returned frame zero")
  `BFA_ASSERT_IMP(a_commit_slot, cmd.rmw_commit || cmd.scan_commit, !out_valid || out_ready, "result loaded over a pending one")
  `BFA_ASSERT_IMP(a_scan_bound, cmd.scan_rd, !issued_all && !hit, "scan read past the map or after a hit")

endmodule

[src/bitmap_frame_allocator.sv]
// Allocate and free read the frame's map word, then write it back and register the
// result once the output slot is free; find first free reads one map word of 64
// frames per cycle from the single memory port, stopping once a free frame is found.
// Throughput: one request at a time; a new request is taken while a result waits.
// Reset (synchronous, active high) and any frame count write free every frame;
// reset sets the frame count to 4096.
module bitmap_frame_allocator import bfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  bfa_req_if.sink   req,
  bfa_rsp_if.source rsp,
  bfa_cfg_if.sink   cfg
);

  cmd_t    cmd;
  status_t status;

  // The count register takes a write in any cycle.
  assign cfg.ready = 1'b1;

  bfa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_is_find (req.mode == MODE_FIND),
    .req_ready   (req.ready),
    .status      (status),
    .cmd         (cmd)
  );

  bfa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_mode   (req.mode),
    .in_frame  (req.frame),
    .cfg_we    (cfg.valid),
    .cfg_data  (cfg.data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_frame (rsp.frame_result),
    .out_ok    (rsp.ok)
  );

endmodule
